FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the execute unit.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bie_pkg.sv
// Package for the byte ISA execute unit: opcodes, status codes, widths.
// No dependencies.
`default_nettype none
package bie_pkg;
  localparam int MemWordsDef = 256;
  localparam int RegCountDef = 256;
  localparam int DataW = 32;
  localparam logic [7:0] ByteMask = 8'd255;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_QUIT  = 2'd1;
  localparam logic [1:0] ST_BADOP = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

  localparam logic [7:0] OP_QUIT = 8'd0;
  localparam logic [7:0] OP_PRR  = 8'd2;
  localparam logic [7:0] OP_PRI  = 8'd3;
  localparam logic [7:0] OP_PCR  = 8'd4;
  localparam logic [7:0] OP_PCI  = 8'd5;
  localparam logic [7:0] OP_LDR  = 8'd32;
  localparam logic [7:0] OP_LDI  = 8'd33;
  localparam logic [7:0] OP_STRR = 8'd34;
  localparam logic [7:0] OP_STRI = 8'd35;
  localparam logic [7:0] OP_STAR = 8'd36;
  localparam logic [7:0] OP_STAI = 8'd37;
  localparam logic [7:0] OP_ADD  = 8'd64;
  localparam logic [7:0] OP_ADDI = 8'd65;
  localparam logic [7:0] OP_SUB  = 8'd66;
  localparam logic [7:0] OP_SUBI = 8'd67;
  localparam logic [7:0] OP_MUL  = 8'd68;
  localparam logic [7:0] OP_MULI = 8'd69;
  localparam logic [7:0] OP_DIV  = 8'd72;
  localparam logic [7:0] OP_DIVI = 8'd73;
  localparam logic [7:0] OP_MOD  = 8'd80;
  localparam logic [7:0] OP_MODI = 8'd81;
  localparam logic [7:0] OP_JMP  = 8'd128;
  localparam logic [7:0] OP_BRLO = 8'd130;
  localparam logic [7:0] OP_BRHI = 8'd139;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_LT = 3'd1;
  localparam logic [2:0] CMP_LE = 3'd2;
  localparam logic [2:0] CMP_GT = 3'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  opcode;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [7:0]  operand_c;
    logic [7:0]  load_addr;
    logic [31:0] load_data;
  } bie_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         next_pc;
    logic               print_valid;
    logic               print_as_char;
    logic signed [31:0] print_value;
    logic               write_valid;
    logic [7:0]         write_reg;
    logic signed [31:0] write_value;
  } bie_out_t;
endpackage
`default_nettype wire

FILE: rtl/bie_if.sv
// Valid/ready channel interfaces for the execute unit.
// Depends on bie_pkg.
`default_nettype none
interface bie_in_if import bie_pkg::*; ();
  logic    valid;
  logic    ready;
  bie_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bie_out_if import bie_pkg::*; ();
  logic     valid;
  logic     ready;
  bie_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bie_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bie_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/byte_isa_execute_unit.sv
// Top level of the byte ISA execute unit: sequencer, register file and data memory
// RAMs, shared divider. Depends on bie_pkg, bie_if, bie_ram, assert_macros.svh.
//
//  channel | dir | handshake     | payload
//  in      | in  | valid/ready   | kind, opcode, operands, load_addr, load_data
//  out     | out | valid/ready   | status, next_pc, print and write fields
//
// After reset a clearing pass zeroes both RAMs. A preload or an item seen while halted
// goes from register A read straight to output; any other instruction reads registers
// A, B and C, then memory, then executes; divide or modulo by a nonzero divisor
// runs the restoring divider first, one quotient bit per cycle over 32 bits. Each
// result transfer returns the unit to idle. Register and memory reads share the
// single read port of each RAM, one a cycle. Reset is synchronous active low; the
// result waits in an output register and no new item is taken until transferred.
`default_nettype none
`include "assert_macros.svh"
module byte_isa_execute_unit import bie_pkg::*; #(
  parameter int MEM_WORDS = MemWordsDef,
  parameter int REG_COUNT = RegCountDef
) (
  input wire logic clk,
  input wire logic rst_n,
  bie_in_if.sink   in_ch,
  bie_out_if.source out_ch
);
  localparam int MAW = $clog2(MEM_WORDS);
  localparam int RAW = $clog2(REG_COUNT);
  localparam int CLRW = (MAW > RAW) ? MAW : RAW;
  localparam int CLRN = (MEM_WORDS > REG_COUNT) ? MEM_WORDS : REG_COUNT;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_RDA  = 9'b000000100,
    S_RDB  = 9'b000001000,
    S_RDC  = 9'b000010000,
    S_MEM  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_EXE  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  bie_in_t itm_r;
  logic [31:0] ra_r, rb_r, rc_r;
  logic [7:0] pc_r;
  logic halted_r;
  logic [CLRW:0] clr_r;
  logic [5:0] cnt_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  bie_out_t res_r;
  logic ov_r;

  // RAM ports
  logic rf_we, dm_we;
  logic [RAW-1:0] rf_wa, rf_ra;
  logic [MAW-1:0] dm_wa, dm_ra;
  logic [31:0] rf_wd, dm_wd, rf_rd, dm_rd;
  logic [RAW-1:0] rf_ra_q;

  bie_ram #(.Width(32), .Depth(REG_COUNT)) u_rf (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd), .raddr(rf_ra), .rdata(rf_rd));
  bie_ram #(.Width(32), .Depth(MEM_WORDS)) u_dm (
    .clk, .we(dm_we), .waddr(dm_wa), .wdata(dm_wd), .raddr(dm_ra), .rdata(dm_rd));

  // register 0 reads zero
  logic [31:0] rf_val;
  assign rf_val = (rf_ra_q == '0) ? 32'd0 : rf_rd;

  wire [7:0] op = itm_r.opcode;
  wire imm = op[0];
  wire is_div = (op == OP_DIV) || (op == OP_DIVI) || (op == OP_MOD) || (op == OP_MODI);
  wire rb_neg = rb_r[31];
  wire rc_neg = rc_r[31];
  wire [31:0] mx = rb_neg ? (32'd0 - rb_r) : rb_r;
  wire [31:0] my = rc_neg ? (32'd0 - rc_r) : rc_r;

  // divider step: shift in one dividend bit, trial subtract
  wire [32:0] trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  // compare for branches
  wire signed [31:0] sb = rb_r;
  wire signed [31:0] sc = rc_r;
  logic br_hit;
  always_comb begin
    case (3'((op - OP_BRLO) >> 1))
      CMP_EQ:  br_hit = sb == sc;
      CMP_LT:  br_hit = sb < sc;
      CMP_LE:  br_hit = sb <= sc;
      CMP_GT:  br_hit = sb > sc;
      default: br_hit = sb >= sc;
    endcase
  end

  // result of an execute
  bie_out_t ex;
  logic dm_st;
  logic [MAW-1:0] st_addr;
  logic [31:0] st_data;
  logic [31:0] q_fix, r_fix;
  always_comb begin
    q_fix = (rb_neg != rc_neg) ? (32'd0 - quo_r) : quo_r;
    r_fix = rb_neg ? (32'd0 - rem_r) : rem_r;
    ex = '0;
    ex.status = ST_OK;
    ex.next_pc = pc_r + 8'd1;
    dm_st = 1'b0;
    st_addr = MAW'(ra_r);
    st_data = rb_r;
    case (op)
      OP_QUIT: ex.status = ST_QUIT;
      OP_PRR, OP_PCR: begin
        ex.print_valid = 1'b1; ex.print_as_char = op[2]; ex.print_value = ra_r;
      end
      OP_PRI, OP_PCI: begin
        ex.print_valid = 1'b1; ex.print_as_char = op[2];
        ex.print_value = {24'd0, itm_r.operand_a};
      end
      OP_LDR, OP_LDI: begin ex.write_valid = 1'b1; ex.write_value = dm_rd; end
      OP_STRR: begin dm_st = 1'b1; end
      OP_STRI: begin dm_st = 1'b1; st_data = {24'd0, itm_r.operand_b}; end
      OP_STAR: begin dm_st = 1'b1; st_addr = MAW'(itm_r.operand_a); end
      OP_STAI: begin
        dm_st = 1'b1; st_addr = MAW'(itm_r.operand_a);
        st_data = {24'd0, itm_r.operand_b};
      end
      OP_ADD, OP_ADDI: begin
        ex.write_valid = 1'b1; ex.write_value = {24'd0, 8'(rb_r + rc_r)};
      end
      OP_SUB, OP_SUBI: begin
        ex.write_valid = 1'b1; ex.write_value = {24'd0, 8'(rb_r - rc_r)};
      end
      OP_MUL, OP_MULI: begin
        ex.write_valid = 1'b1; ex.write_value = {24'd0, 8'(rb_r[7:0] * rc_r[7:0])};
      end
      OP_DIV, OP_DIVI, OP_MOD, OP_MODI: begin
        if (rc_r == 32'd0) ex.status = ST_DIV0;
        else begin
          ex.write_valid = 1'b1;
          ex.write_value = op[4] ? r_fix : q_fix;
        end
      end
      OP_JMP: ex.next_pc = itm_r.operand_a;
      default: begin
        if (op >= OP_BRLO && op <= OP_BRHI) begin
          if (br_hit) ex.next_pc = itm_r.operand_a;
        end else ex.status = ST_BADOP;
      end
    endcase
    if (ex.status == ST_BADOP || ex.status == ST_DIV0) begin
      ex.next_pc = pc_r; ex.write_valid = 1'b0; ex.write_value = '0; dm_st = 1'b0;
    end
    if (RAW'(itm_r.operand_a) == '0) begin
      ex.write_valid = 1'b0; ex.write_value = '0;
    end
    ex.write_reg = ex.write_valid ? itm_r.operand_a : 8'd0;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == (CLRW+1)'(CLRN - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_ch.valid) state_nxt = S_RDA;
      S_RDA:  state_nxt = (itm_r.kind || halted_r) ? S_OUT : S_RDB;
      S_RDB:  state_nxt = S_RDC;
      S_RDC:  state_nxt = S_MEM;
      S_MEM:  state_nxt = (is_div && rc_r != 32'd0) ? S_DIV : S_EXE;
      S_DIV:  if (cnt_r == 6'd31) state_nxt = S_EXE;
      S_EXE:  state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM address and write control; the load address is held until execute
  always_comb begin
    rf_we = 1'b0; rf_wa = RAW'(itm_r.operand_a); rf_wd = ex.write_value;
    dm_we = 1'b0; dm_wa = st_addr; dm_wd = st_data;
    rf_ra = RAW'(itm_r.operand_a);
    dm_ra = (op == OP_LDR) ? MAW'(rb_r) : MAW'(itm_r.operand_b);
    case (state_r)
      S_CLR: begin
        rf_we = (clr_r < (CLRW+1)'(REG_COUNT));
        rf_wa = RAW'(clr_r); rf_wd = '0;
        dm_we = (clr_r < (CLRW+1)'(MEM_WORDS));
        dm_wa = MAW'(clr_r); dm_wd = '0;
      end
      S_IDLE: rf_ra = RAW'(in_ch.data.operand_a);
      S_RDA: begin
        rf_ra = RAW'(itm_r.operand_b);
        dm_we = itm_r.kind; dm_wa = MAW'(itm_r.load_addr); dm_wd = itm_r.load_data;
      end
      S_RDB: rf_ra = RAW'(itm_r.operand_c);
      S_EXE: begin
        rf_we = ex.write_valid;
        dm_we = dm_st;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rf_ra_q <= rf_ra;
    case (state_r)
      S_IDLE: itm_r <= in_ch.data;
      S_RDA:  ra_r <= rf_val;
      S_RDB:  rb_r <= rf_val;
      S_RDC:  rc_r <= imm ? {24'd0, itm_r.operand_c} : rf_val;
      S_MEM: begin
        rem_r <= '0; quo_r <= mx; dvs_r <= my; cnt_r <= '0;
      end
      S_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (!trial[32]) begin
          rem_r <= trial[31:0]; quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], quo_r[31]}; quo_r <= {quo_r[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; pc_r <= '0; halted_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == S_RDA && (itm_r.kind || halted_r)) begin
        res_r <= '0;
        res_r.status <= itm_r.kind ? ST_OK : ST_QUIT;
        res_r.next_pc <= pc_r;
        ov_r <= 1'b1;
      end
      if (state_r == S_EXE) begin
        res_r <= ex; pc_r <= ex.next_pc; ov_r <= 1'b1;
        if (ex.status == ST_QUIT) halted_r <= 1'b1;
      end
      if (state_r == S_OUT && out_ch.ready) ov_r <= 1'b0;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data = res_r;

  `ASSERT_IMPL(a_out_flag, clk, rst_n, out_ch.valid, ov_r, "result shown without a stored result")
  `ASSERT_IMPL(a_excl, clk, rst_n, in_ch.ready, !out_ch.valid, "input and output open together")
  `ASSERT_NEXT(a_halt_keep, clk, rst_n, halted_r, halted_r, "halt flag cleared")
  `ASSERT_IMPL(a_r0, clk, rst_n, out_ch.valid && out_ch.data.write_valid,
               out_ch.data.write_reg != 8'd0, "write to register zero reported")
endmodule
`default_nettype wire
